// ----- src/ovl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

   localparam int LIST_DEPTH  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 4;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_DELETE = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [VALUE_W-1:0] item_value;
      logic signed [VALUE_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] out_value;
      logic [POS_W-1:0]          out_position;
      logic                      last;
   } rsp_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_FULL,
      EM_INSERT,
      EM_EMPTY,
      EM_MISS,
      EM_ENTRY,
      EM_UPDATE,
      EM_DELETE
   } emit_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_INSERT,
      WR_UPDATE,
      WR_SHIFT
   } wsel_type;

   typedef struct packed {
      logic     load;
      logic     issue;
      logic     capture;
      wsel_type wsel;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       full;
      logic       empty;
      logic       pvalid;
      logic       key_hit;
      logic       fill_end;
      logic       read_end;
      logic       hit_end;
   } stat_type;

endpackage

`default_nettype wire

// ----- src/ordered_value_list_table.sv -----
// insert, a full list, an empty read and a miss on an empty list: result registered from dispatch
// read: each RAM read is registered, then its entry is registered out, one entry per cycle
// update: result follows the first match; a miss after a search ends at the last entry
// delete: the search and the shift down walk one entry per cycle
// one transaction at a time, next accept at the edge of the final result; receiver cannot stall
// synchronous reset empties the list and returns the controller to idle
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list_table #(
   parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ovl_pkg::req_type req_data,
   output logic                  rsp_valid,
   output ovl_pkg::rsp_type      rsp_data
);

   ovl_pkg::cmd_type  cmd;
   ovl_pkg::stat_type stat;

   ovl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ovl_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/ovl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ovl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/ovl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ovl_dp #(
   parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ovl_pkg::req_type req_data,
   input  wire ovl_pkg::cmd_type cmd,
   output ovl_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output ovl_pkg::rsp_type      rsp_data
);

   localparam int AW     = $clog2(LIST_DEPTH);
   localparam int CW     = $clog2(LIST_DEPTH + 1);
   localparam int LimInt = (ovl_pkg::MAX_RESULTS < LIST_DEPTH) ?
                           ovl_pkg::MAX_RESULTS : LIST_DEPTH;
   localparam logic [CW-1:0] Lim  = CW'(LimInt);
   localparam logic [CW-1:0] Full = CW'(LIST_DEPTH);

   ovl_pkg::req_type req_ff, req_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    pidx_ff, pidx_in;
   logic [CW-1:0]    hit_ff, hit_in;
   logic             pv_ff, pv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ovl_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]    bound;
   logic [CW-1:0]    lim;
   logic [CW-1:0]    pidx_next;
   logic [CW-1:0]    pidx_prev;
   logic             in_range;

   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [ovl_pkg::VALUE_W-1:0] rd_data;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [ovl_pkg::VALUE_W-1:0] wr_data;

   ovl_ram #(
      .WIDTH (ovl_pkg::VALUE_W),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      lim       = (fill_ff > Lim) ? Lim : fill_ff;
      bound     = (req_ff.opcode == ovl_pkg::OP_READ) ? lim : fill_ff;
      in_range  = (rptr_ff < bound);
      pidx_next = pidx_ff + CW'(1);
      pidx_prev = pidx_ff - CW'(1);

      stat.opcode   = req_ff.opcode;
      stat.full     = (fill_ff == Full);
      stat.empty    = (fill_ff == '0);
      stat.pvalid   = pv_ff;
      stat.key_hit  = (rd_data == req_ff.item_value);
      stat.fill_end = (pidx_next == fill_ff);
      stat.read_end = (pidx_next == lim);
      stat.hit_end  = ((hit_ff + CW'(1)) == fill_ff);
   end

   // read pointer and compare pipe
   always_comb begin
      req_in  = req_ff;
      rptr_in = rptr_ff;
      pidx_in = pidx_ff;
      hit_in  = hit_ff;
      pv_in   = 1'b0;
      rd_en   = 1'b0;
      rd_addr = rptr_ff[AW-1:0];
      if (cmd.load) begin
         req_in  = req_data;
         rptr_in = '0;
      end else if (cmd.capture) begin
         hit_in  = pidx_ff;
         rptr_in = pidx_next;
      end else if (cmd.issue && in_range) begin
         rd_en   = 1'b1;
         pv_in   = 1'b1;
         pidx_in = rptr_ff;
         rptr_in = rptr_ff + CW'(1);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[AW-1:0];
      wr_data = req_ff.item_value;
      case (cmd.wsel)
         ovl_pkg::WR_INSERT: begin
            wr_en = 1'b1;
         end
         ovl_pkg::WR_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = pidx_ff[AW-1:0];
            wr_data = req_ff.new_value;
         end
         ovl_pkg::WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = pidx_prev[AW-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_in             = fill_ff;
      rsp_valid_in        = 1'b1;
      rsp_in.status       = ovl_pkg::ST_DONE;
      rsp_in.out_value    = '0;
      rsp_in.out_position = '0;
      rsp_in.last         = 1'b1;
      case (cmd.emit)
         ovl_pkg::EM_FULL: begin
            rsp_in.status = ovl_pkg::ST_FULL;
         end
         ovl_pkg::EM_INSERT: begin
            rsp_in.out_position = ovl_pkg::POS_W'(fill_ff);
            fill_in             = fill_ff + CW'(1);
         end
         ovl_pkg::EM_EMPTY: begin
            rsp_in.status = ovl_pkg::ST_EMPTY;
         end
         ovl_pkg::EM_MISS: begin
            rsp_in.status = ovl_pkg::ST_NOT_FOUND;
         end
         ovl_pkg::EM_ENTRY: begin
            rsp_in.out_value    = rd_data;
            rsp_in.out_position = ovl_pkg::POS_W'(pidx_ff);
            rsp_in.last         = stat.read_end;
         end
         ovl_pkg::EM_UPDATE: begin
            rsp_in.out_position = ovl_pkg::POS_W'(pidx_ff);
         end
         ovl_pkg::EM_DELETE: begin
            rsp_in.out_position = ovl_pkg::POS_W'(hit_ff);
            fill_in             = fill_ff - CW'(1);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      rptr_ff <= rptr_in;
      pidx_ff <= pidx_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/ovl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ovl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ovl_pkg::stat_type stat,
   output ovl_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_SEARCH,
      S_SHIFT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.issue   = 1'b0;
      cmd.capture = 1'b0;
      cmd.wsel    = ovl_pkg::WR_NONE;
      cmd.emit    = ovl_pkg::EM_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            case (stat.opcode)
               ovl_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     cmd.emit = ovl_pkg::EM_FULL;
                  end else begin
                     cmd.wsel = ovl_pkg::WR_INSERT;
                     cmd.emit = ovl_pkg::EM_INSERT;
                  end
               end
               ovl_pkg::OP_READ: begin
                  if (stat.empty) begin
                     cmd.emit = ovl_pkg::EM_EMPTY;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.emit = ovl_pkg::EM_MISS;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
            endcase
         end
         S_READ: begin
            cmd.issue = 1'b1;
            if (stat.pvalid) begin
               cmd.emit = ovl_pkg::EM_ENTRY;
               if (stat.read_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SEARCH: begin
            cmd.issue = 1'b1;
            if (stat.pvalid) begin
               if (stat.key_hit) begin
                  if (stat.opcode == ovl_pkg::OP_UPDATE) begin
                     cmd.wsel = ovl_pkg::WR_UPDATE;
                     cmd.emit = ovl_pkg::EM_UPDATE;
                     state_in = S_IDLE;
                  end else begin
                     cmd.capture = 1'b1;
                     state_in    = S_SHIFT;
                  end
               end else if (stat.fill_end) begin
                  cmd.emit = ovl_pkg::EM_MISS;
                  state_in = S_IDLE;
               end
            end
         end
         S_SHIFT: begin
            cmd.issue = 1'b1;
            if (stat.hit_end) begin
               cmd.emit = ovl_pkg::EM_DELETE;
               state_in = S_IDLE;
            end else if (stat.pvalid) begin
               cmd.wsel = ovl_pkg::WR_SHIFT;
               if (stat.fill_end) begin
                  cmd.emit = ovl_pkg::EM_DELETE;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ----- test/ordered_value_list_table_tb.sv -----
`timescale 1ns / 1ps

module ordered_value_list_table_tb;

   localparam int ITEM_COUNT     = 250;
   localparam int CALM_TAIL      = 40;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [ovl_pkg::VALUE_W-1:0] VALUE_MIN =
      {1'b1, {(ovl_pkg::VALUE_W-1){1'b0}}};
   localparam logic signed [ovl_pkg::VALUE_W-1:0] VALUE_MAX =
      {1'b0, {(ovl_pkg::VALUE_W-1){1'b1}}};

   class list_scoreboard;
      logic signed [ovl_pkg::VALUE_W-1:0] entries [ovl_pkg::LIST_DEPTH];
      int               fill;
      ovl_pkg::rsp_type pending_results [$];
      int               errors;
      int               op_count [4];
      int               result_count;
      int               full_drops;
      int               empty_reads;
      int               misses;

      function new();
         fill         = 0;
         errors       = 0;
         result_count = 0;
         full_drops   = 0;
         empty_reads  = 0;
         misses       = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function void add_result(logic [1:0] status,
                               logic signed [ovl_pkg::VALUE_W-1:0] value,
                               int pos, bit last);
         ovl_pkg::rsp_type r;
         r.status       = status;
         r.out_value    = value;
         r.out_position = ovl_pkg::POS_W'(pos);
         r.last         = last;
         pending_results = {pending_results, r};
      endfunction

      function int find_first(logic signed [ovl_pkg::VALUE_W-1:0] key);
         for (int i = 0; i < fill; i++) begin
            if (entries[i] == key) return i;
         end
         return fill;
      endfunction

      function void note_request(ovl_pkg::req_type r);
         int hit;
         op_count[r.opcode]++;
         case (r.opcode)
            ovl_pkg::OP_INSERT: begin
               if (fill >= ovl_pkg::LIST_DEPTH) begin
                  full_drops++;
                  add_result(ovl_pkg::ST_FULL, '0, 0, 1'b1);
               end else begin
                  entries[fill] = r.item_value;
                  add_result(ovl_pkg::ST_DONE, '0, fill, 1'b1);
                  fill++;
               end
            end
            ovl_pkg::OP_READ: begin
               if (fill == 0) begin
                  empty_reads++;
                  add_result(ovl_pkg::ST_EMPTY, '0, 0, 1'b1);
               end else begin
                  for (int i = 0; i < fill && i < ovl_pkg::MAX_RESULTS; i++)
                     add_result(ovl_pkg::ST_DONE, entries[i], i,
                                (i + 1 == fill) || (i + 1 == ovl_pkg::MAX_RESULTS));
               end
            end
            ovl_pkg::OP_UPDATE, ovl_pkg::OP_DELETE: begin
               hit = find_first(r.item_value);
               if (hit >= fill) begin
                  misses++;
                  add_result(ovl_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
               end else begin
                  if (r.opcode == ovl_pkg::OP_UPDATE) begin
                     entries[hit] = r.new_value;
                  end else begin
                     for (int i = hit; i + 1 < fill; i++) entries[i] = entries[i + 1];
                     fill--;
                  end
                  add_result(ovl_pkg::ST_DONE, '0, hit, 1'b1);
               end
            end
         endcase
      endfunction

      function void check_result(ovl_pkg::rsp_type got);
         ovl_pkg::rsp_type want;
         result_count++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result: status %0d value %0d position %0d last %0d",
                     $time, got.status, got.out_value, got.out_position, got.last);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) begin
            errors++;
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
         end
         if (got.out_value !== want.out_value) begin
            errors++;
            $display("%0t out_value mismatch: expected %0d, actual %0d",
                     $time, want.out_value, got.out_value);
         end
         if (got.out_position !== want.out_position) begin
            errors++;
            $display("%0t out_position mismatch: expected %0d, actual %0d",
                     $time, want.out_position, got.out_position);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t last mismatch: expected %0d, actual %0d",
                     $time, want.last, got.last);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   ovl_pkg::req_type req_data;
   logic             rsp_valid;
   ovl_pkg::rsp_type rsp_data;
   list_scoreboard   sb;
   int               quiet_cycles = 0;

   ordered_value_list_table uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (start && !busy) sb.note_request(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [ovl_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return '1;
         4, 5: return ovl_pkg::VALUE_W'($urandom_range(0, 7));
         6: return -(ovl_pkg::VALUE_W'($urandom_range(1, 4)));
         default: return $urandom;
      endcase
   endfunction

   function automatic ovl_pkg::req_type cmd(logic [1:0] op,
                                            logic signed [ovl_pkg::VALUE_W-1:0] key,
                                            logic signed [ovl_pkg::VALUE_W-1:0] repl);
      ovl_pkg::req_type r;
      r.opcode     = op;
      r.item_value = key;
      r.new_value  = repl;
      return r;
   endfunction

   // random contents are built at the falling edge so the list state is settled
   task automatic send_item(input bit make_random, input int insert_pct,
                            input ovl_pkg::req_type fixed);
      ovl_pkg::req_type r;
      int               roll;
      int               span;
      @(negedge clock);
      r = fixed;
      if (make_random) begin
         roll        = $urandom_range(0, 99);
         span        = 100 - insert_pct;
         r.new_value = $urandom;
         if (roll < insert_pct) begin
            r.opcode     = ovl_pkg::OP_INSERT;
            r.item_value = pick_value();
         end else begin
            roll -= insert_pct;
            if (roll < span / 5) r.opcode = ovl_pkg::OP_READ;
            else if (roll < span * 3 / 5) r.opcode = ovl_pkg::OP_UPDATE;
            else r.opcode = ovl_pkg::OP_DELETE;
            if (sb.fill > 0 && $urandom_range(0, 9) < 7)
               r.item_value = sb.entries[$urandom_range(0, sb.fill - 1)];
            else
               r.item_value = pick_value();
         end
      end
      start    <= 1'b1;
      req_data <= r;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic rest(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_results.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb       = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(1'b0, 0, cmd(ovl_pkg::OP_READ, '0, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_UPDATE, VALUE_MAX, 32'sd5));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_DELETE, VALUE_MIN, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, VALUE_MIN, VALUE_MAX));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, VALUE_MAX, VALUE_MIN));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, '0, '1));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, '1, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, VALUE_MAX, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_READ, '1, '1));
      // duplicate keys: only the lowest index is touched
      send_item(1'b0, 0, cmd(ovl_pkg::OP_UPDATE, VALUE_MAX, VALUE_MIN));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_UPDATE, 32'sd12345, '1));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_DELETE, VALUE_MIN, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_READ, '0, '0));
      for (int i = 0; i < 12; i++)
         send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, 32'sd100 + i, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_INSERT, 32'sd7, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_READ, '0, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_DELETE, VALUE_MAX, '0));
      send_item(1'b0, 0, cmd(ovl_pkg::OP_DELETE, 32'sd111, '0));

      for (int k = 0; k < ITEM_COUNT; k++) begin
         if (k == ITEM_COUNT / 2) drain();
         if (k < ITEM_COUNT - CALM_TAIL && (k / 20) % 3 != 2 && $urandom_range(0, 3) == 0)
            rest($urandom_range(1, 17));
         send_item(1'b1, ((k / 40) % 2 == 0) ? 60 : 20, '0);
      end
      @(negedge clock);
      start <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d transactions (%0d insert, %0d read, %0d update, %0d delete)",
               sb.op_count[ovl_pkg::OP_INSERT] + sb.op_count[ovl_pkg::OP_READ]
               + sb.op_count[ovl_pkg::OP_UPDATE] + sb.op_count[ovl_pkg::OP_DELETE],
               sb.op_count[ovl_pkg::OP_INSERT], sb.op_count[ovl_pkg::OP_READ],
               sb.op_count[ovl_pkg::OP_UPDATE], sb.op_count[ovl_pkg::OP_DELETE]);
      $display("%0d results checked, %0d full drops, %0d empty reads, %0d key misses",
               sb.result_count, sb.full_drops, sb.empty_reads, sb.misses);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
